### hdl/sabd_pkg.sv
// sabd_pkg: shared widths, register indexes and constants for the ssd anchor box decoder
// no dependencies; used by the channel interfaces and the top level
package sabd_pkg;

    // field widths
    localparam int DATA_W  = 16;   // score and raw box values, signed
    localparam int PIX_W   = 14;   // pixel outputs
    localparam int IDX_W   = 10;   // anchor index
    localparam int ANCH_W  = 14;   // anchor centre in 1/16384 of the frame
    localparam int Q_W     = 18;   // normalised position before scaling, signed

    // anchor layout
    localparam int NUM_ANCHORS  = 896;
    localparam int FINE_ANCHORS = 512;

    // fixed point
    localparam int FRAC_SHIFT = 14;
    localparam int PIX_MAX    = 16383;

    // reciprocal for the coarse grid: cell = ((m >> 1) * 171) >> 9, exact for m >> 1 below 512
    localparam int RECIP3     = 171;
    localparam int RECIP3_SH  = 9;

    // configuration register layout
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH     = 2'd0,
        REG_FRAME_HEIGHT    = 2'd1,
        REG_SCORE_THRESHOLD = 2'd2
    } t_reg_idx;

    // coordinate slots in the datapath arrays
    localparam int C_LEFT   = 0;
    localparam int C_TOP    = 1;
    localparam int C_WIDTH  = 2;
    localparam int C_HEIGHT = 3;
    localparam int NUM_COORD = 4;

endpackage

### hdl/sabd_if.sv
// sabd_in_if / sabd_out_if: valid-ready channels for detector outputs and decoded boxes
// depends on sabd_pkg for field widths
interface sabd_in_if import sabd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] score;
    logic signed [DATA_W-1:0] raw_x_center;
    logic signed [DATA_W-1:0] raw_y_center;
    logic signed [DATA_W-1:0] raw_width;
    logic signed [DATA_W-1:0] raw_height;

    modport source (
        output valid, score, raw_x_center, raw_y_center, raw_width, raw_height,
        input  ready
    );
    modport sink (
        input  valid, score, raw_x_center, raw_y_center, raw_width, raw_height,
        output ready
    );
endinterface

interface sabd_out_if import sabd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             keep;
    logic [PIX_W-1:0] box_left;
    logic [PIX_W-1:0] box_top;
    logic [PIX_W-1:0] box_width_px;
    logic [PIX_W-1:0] box_height_px;
    logic [IDX_W-1:0] anchor_index;
    logic             last_anchor;

    modport source (
        output valid, keep, box_left, box_top, box_width_px, box_height_px,
               anchor_index, last_anchor,
        input  ready
    );
    modport sink (
        input  valid, keep, box_left, box_top, box_width_px, box_height_px,
               anchor_index, last_anchor,
        output ready
    );
endinterface

### hdl/ssd_anchor_box_decoder_unit.sv
// each item is held first in the input register, then in the result register
// throughput: one transfer per cycle in and out while the sink takes results;
// set by the two-register pipeline, each stage moves when the next frees
// reset (i_rst_n, synchronous, active low): pipeline empty, anchor counter 0,
// frame 640 x 480 (truncated to FRAME_DIM_BITS), score threshold 128 (0.5 in Q8.8)
// depends on sabd_pkg and the channel interfaces in sabd_if.sv
module ssd_anchor_box_decoder_unit import sabd_pkg::*; #(
    parameter int FRAME_DIM_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // streams
    sabd_in_if.sink               i_in,
    sabd_out_if.source            o_out
);

    // product width: signed Q_W position times unsigned frame dimension
    localparam int PW   = Q_W + FRAME_DIM_BITS + 1;
    // width of the product once the fraction is dropped
    localparam int SH_W = PW - FRAC_SHIFT;
    localparam int EXT_W = SH_W + PIX_W;

    localparam logic [FRAME_DIM_BITS-1:0] WIDTH_RST  = FRAME_DIM_BITS'(640);
    localparam logic [FRAME_DIM_BITS-1:0] HEIGHT_RST = FRAME_DIM_BITS'(480);
    localparam logic signed [DATA_W-1:0]  THR_RST    = DATA_W'(128);
    localparam logic [IDX_W-1:0]          LAST_IDX   = IDX_W'(NUM_ANCHORS - 1);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [FRAME_DIM_BITS-1:0] r_frame_w;
    logic [FRAME_DIM_BITS-1:0] r_frame_h;
    logic signed [DATA_W-1:0]  r_thr;
    logic                      cfg_wr;
    t_reg_idx                  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= WIDTH_RST;
            r_frame_h <= HEIGHT_RST;
            r_thr     <= THR_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FRAME_WIDTH:     r_frame_w <= pwdata[FRAME_DIM_BITS-1:0];
                REG_FRAME_HEIGHT:    r_frame_h <= pwdata[FRAME_DIM_BITS-1:0];
                REG_SCORE_THRESHOLD: r_thr     <= signed'(pwdata[DATA_W-1:0]);
                default: begin
                    // unmapped slot, write dropped
                end
            endcase
        end
    end

    // read back, threshold sign extended
    always_comb begin
        case (cfg_idx)
            REG_FRAME_WIDTH:     prdata = CFG_DATA_W'(r_frame_w);
            REG_FRAME_HEIGHT:    prdata = CFG_DATA_W'(r_frame_h);
            REG_SCORE_THRESHOLD: prdata = CFG_DATA_W'(r_thr);
            default:             prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // pipeline flow control
    // each stage loads when it is empty or its contents move on
    // ---------------------------------------------------------------
    logic r_v1, r_v2;
    logic adv1, adv2;
    logic in_xfer;

    assign adv2     = !r_v2 || o_out.ready;
    assign adv1     = !r_v1 || adv2;
    assign i_in.ready = adv1;
    assign in_xfer  = i_in.valid && adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in.valid;
            if (adv2) r_v2 <= r_v1;
        end
    end

    // ---------------------------------------------------------------
    // anchor counter and anchor centre lookup
    // fine grid: 16 x 16 cells, 2 anchors each, centre (2*cell+1)*512
    // coarse grid: 8 x 8 cells, 6 anchors each, centre (2*cell+1)*1024
    // ---------------------------------------------------------------
    logic [IDX_W-1:0]  r_anchor_cnt;
    logic [IDX_W-1:0]  n_anchor_cnt;
    logic [8:0]        coarse_off;
    logic [15:0]       coarse_mul;
    logic [5:0]        coarse_cell;
    logic [7:0]        fine_cell;
    logic [ANCH_W-1:0] anch_x;
    logic [ANCH_W-1:0] anch_y;

    assign n_anchor_cnt = (r_anchor_cnt == LAST_IDX) ? '0 : r_anchor_cnt + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_cnt <= '0;
        end else if (in_xfer) begin
            r_anchor_cnt <= n_anchor_cnt;
        end
    end

    always_comb begin
        fine_cell   = r_anchor_cnt[8:1];
        coarse_off  = 9'(r_anchor_cnt - IDX_W'(FINE_ANCHORS));
        // divide by 6: halve, then times the reciprocal of 3
        coarse_mul  = 16'(coarse_off[8:1]) * 16'(RECIP3);
        coarse_cell = coarse_mul[RECIP3_SH+5:RECIP3_SH];
        if (r_anchor_cnt < IDX_W'(FINE_ANCHORS)) begin
            anch_x = {1'b0, fine_cell[3:0], 1'b1, 8'b0};
            anch_y = {1'b0, fine_cell[7:4], 1'b1, 8'b0};
        end else begin
            anch_x = {coarse_cell[2:0], 1'b1, 10'b0};
            anch_y = {coarse_cell[5:3], 1'b1, 10'b0};
        end
        // fine centres are (2c+1)*512: shift the whole field left by one
        if (r_anchor_cnt < IDX_W'(FINE_ANCHORS)) begin
            anch_x = {anch_x[ANCH_W-2:0], 1'b0};
            anch_y = {anch_y[ANCH_W-2:0], 1'b0};
        end
    end

    // ---------------------------------------------------------------
    // stage 1: input register
    // ---------------------------------------------------------------
    logic signed [DATA_W-1:0] r1_score;
    logic signed [DATA_W-1:0] r1_rx, r1_ry, r1_rw, r1_rh;
    logic [ANCH_W-1:0]        r1_ax, r1_ay;
    logic [IDX_W-1:0]         r1_idx;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r1_score <= i_in.score;
            r1_rx    <= i_in.raw_x_center;
            r1_ry    <= i_in.raw_y_center;
            r1_rw    <= i_in.raw_width;
            r1_rh    <= i_in.raw_height;
            r1_ax    <= anch_x;
            r1_ay    <= anch_y;
            r1_idx   <= r_anchor_cnt;
        end
    end

    // ---------------------------------------------------------------
    // stage 1 -> 2: position in 1/16384 of the frame, then scale by frame size
    //   left = 2*x + ax - w, top = 2*y + ay - h, width = 2*w, height = 2*h
    // ---------------------------------------------------------------
    logic signed [Q_W-1:0] q     [NUM_COORD];
    logic signed [PW-1:0]  q_ext [NUM_COORD];
    logic signed [PW-1:0]  dim   [NUM_COORD];
    logic signed [PW-1:0]  prod  [NUM_COORD];
    logic signed [Q_W-1:0] rx_e, ry_e, rw_e, rh_e;
    logic signed [Q_W-1:0] ax_e, ay_e;

    always_comb begin
        rx_e = Q_W'(r1_rx);
        ry_e = Q_W'(r1_ry);
        rw_e = Q_W'(r1_rw);
        rh_e = Q_W'(r1_rh);
        ax_e = signed'(Q_W'(r1_ax));
        ay_e = signed'(Q_W'(r1_ay));
        q[C_LEFT]   = (rx_e <<< 1) + ax_e - rw_e;
        q[C_TOP]    = (ry_e <<< 1) + ay_e - rh_e;
        q[C_WIDTH]  = rw_e <<< 1;
        q[C_HEIGHT] = rh_e <<< 1;
        dim[C_LEFT]   = signed'(PW'(r_frame_w));
        dim[C_TOP]    = signed'(PW'(r_frame_h));
        dim[C_WIDTH]  = signed'(PW'(r_frame_w));
        dim[C_HEIGHT] = signed'(PW'(r_frame_h));
        for (int c = 0; c < NUM_COORD; c++) begin
            q_ext[c] = PW'(q[c]);
            prod[c]  = q_ext[c] * dim[c];
        end
    end

    // ---------------------------------------------------------------
    // keep decision, truncate to whole pixels, saturate, zero every field of a dropped box
    // a zero frame size gives a zero product, which counts as non-negative
    // ---------------------------------------------------------------
    logic             keep;
    logic [EXT_W-1:0] shifted [NUM_COORD];
    logic [PIX_W-1:0] pix     [NUM_COORD];

    always_comb begin
        keep = (r1_score > r_thr);
        for (int c = 0; c < NUM_COORD; c++) begin
            keep = keep && !prod[c][PW-1];
        end
        for (int c = 0; c < NUM_COORD; c++) begin
            shifted[c] = EXT_W'(prod[c][PW-1:FRAC_SHIFT]);
            if (!keep) begin
                pix[c] = '0;
            end else if (shifted[c] > EXT_W'(PIX_MAX)) begin
                pix[c] = PIX_W'(PIX_MAX);
            end else begin
                pix[c] = shifted[c][PIX_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 2: result register
    // ---------------------------------------------------------------
    logic             r2_keep;
    logic [PIX_W-1:0] r2_pix [NUM_COORD];
    logic [IDX_W-1:0] r2_idx;
    logic             r2_last;

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r2_keep <= keep;
            for (int c = 0; c < NUM_COORD; c++) begin
                r2_pix[c] <= pix[c];
            end
            r2_idx  <= r1_idx;
            r2_last <= (r1_idx == LAST_IDX);
        end
    end

    assign o_out.valid         = r_v2;
    assign o_out.keep          = r2_keep;
    assign o_out.box_left      = r2_pix[C_LEFT];
    assign o_out.box_top       = r2_pix[C_TOP];
    assign o_out.box_width_px  = r2_pix[C_WIDTH];
    assign o_out.box_height_px = r2_pix[C_HEIGHT];
    assign o_out.anchor_index  = r2_idx;
    assign o_out.last_anchor   = r2_last;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_anchor_cnt <= LAST_IDX)
        else $error("anchor counter past final anchor");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r2_last == (r2_idx == LAST_IDX)))
        else $error("last anchor flag does not match index");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !r2_keep) |-> (r2_pix[C_LEFT] == '0 && r2_pix[C_TOP] == '0 &&
                                r2_pix[C_WIDTH] == '0 && r2_pix[C_HEIGHT] == '0))
        else $error("dropped box carries non-zero fields");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !o_out.ready) |=> (r_v2 && $stable(r2_idx)))
        else $error("stalled result lost or changed");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && $past(i_rst_n) && r_anchor_cnt != LAST_IDX) |=>
            (r_anchor_cnt == $past(r_anchor_cnt) + IDX_W'(1)))
        else $error("anchor counter did not advance on transfer");

endmodule

### bench/tb_ssd_anchor_box_decoder_unit.sv
`timescale 1ns / 100ps
// tb_ssd_anchor_box_decoder_unit: self-checking bench for the anchor box decoder, a directed
// table then random phases, every box checked against an in-bench box predictor
// depends on sabd_pkg, the channel interfaces in sabd_if.sv and the decoder top level
module tb_ssd_anchor_box_decoder_unit;
    import sabd_pkg::*;

    localparam int FRAME_BITS      = 12;
    localparam int FINE_GRID       = 16;
    localparam int FINE_PER_CELL   = 2;
    localparam int COARSE_GRID     = 8;
    localparam int COARSE_PER_CELL = 6;
    localparam int NUM_PHASES      = 6;
    localparam int PHASE_ITEMS     = 250;
    localparam int PRINT_CAP       = 100;

    // an index with no register behind it, writes there must be dropped
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    // one detector output as it enters the decoder
    typedef struct packed {
        logic signed [DATA_W-1:0] score;
        logic signed [DATA_W-1:0] x_ctr;
        logic signed [DATA_W-1:0] y_ctr;
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] h;
    } t_det;

    // one decoded box as it leaves
    typedef struct packed {
        logic             keep;
        logic [PIX_W-1:0] left_px;
        logic [PIX_W-1:0] top_px;
        logic [PIX_W-1:0] width_px;
        logic [PIX_W-1:0] height_px;
        logic [IDX_W-1:0] index;
        logic             last;
    } t_box;

    // a box typed into the directed rows, used in place of the predicted keep and pixel fields
    typedef struct packed {
        bit   used;
        t_box box;
    } t_fixed;

    typedef enum {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_det        det;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        bit          fixed;
        t_box        box;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    sabd_in_if  in_ch ();
    sabd_out_if out_ch ();

    ssd_anchor_box_decoder_unit #(
        .FRAME_DIM_BITS (FRAME_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // mirror of the decoder's registers and anchor counter, as left after reset
    logic [FRAME_BITS-1:0]    frame_w    = 12'd640;
    logic [FRAME_BITS-1:0]    frame_h    = 12'd480;
    logic signed [DATA_W-1:0] score_thr  = 16'sd128;
    logic [IDX_W-1:0]         anchor_now = '0;

    t_box   box_due_q[$];    // boxes predicted but not yet seen on the output
    t_fixed fixed_q[$];      // one entry per driven item, in transfer order
    t_row   dir_rows[$];
    int     mismatch_cnt = 0;
    bit     quiet = 1'b0;    // no gaps and no stalls once set

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_cnt < PRINT_CAP)
            $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // append one row to the directed table
    function automatic void add_row(input t_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // normalised position to pixels: truncate, clamp at the top of the pixel range
    function automatic logic [PIX_W-1:0] to_px(input longint q);
        longint p;
        p = q >>> FRAC_SHIFT;
        if (q <= 0)
            return '0;
        return (p > PIX_MAX) ? PIX_W'(PIX_MAX) : p[PIX_W-1:0];
    endfunction

    // box for one detector output at anchor n, under the mirrored registers
    function automatic t_box decode_box(input t_det d, input logic [IDX_W-1:0] n);
        int unsigned cell_no;
        longint      step, ax, ay, lq, tq, wq, hq, fw, fh;
        t_box        b;
        if (n < FINE_ANCHORS) begin
            // 16x16 grid, anchor centres on odd multiples of 1/32 of the frame
            cell_no = n / FINE_PER_CELL;
            step = (longint'(1) << FRAC_SHIFT) / (2 * FINE_GRID);
            ax   = longint'(2 * (cell_no % FINE_GRID) + 1) * step;
            ay   = longint'(2 * ((cell_no / FINE_GRID) % FINE_GRID) + 1) * step;
        end else begin
            // 8x8 grid, six anchors share each cell
            cell_no = (n - FINE_ANCHORS) / COARSE_PER_CELL;
            step = (longint'(1) << FRAC_SHIFT) / (2 * COARSE_GRID);
            ax   = longint'(2 * (cell_no % COARSE_GRID) + 1) * step;
            ay   = longint'(2 * ((cell_no / COARSE_GRID) % COARSE_GRID) + 1) * step;
        end
        fw = longint'(frame_w);
        fh = longint'(frame_h);
        lq = (2 * longint'(d.x_ctr) + ax - longint'(d.w)) * fw;
        tq = (2 * longint'(d.y_ctr) + ay - longint'(d.h)) * fh;
        wq = 2 * longint'(d.w) * fw;
        hq = 2 * longint'(d.h) * fh;
        b.keep      = (d.score > score_thr) && lq >= 0 && tq >= 0 && wq >= 0 && hq >= 0;
        // a dropped box reports left, top, width and height as zero
        b.left_px   = b.keep ? to_px(lq) : '0;
        b.top_px    = b.keep ? to_px(tq) : '0;
        b.width_px  = b.keep ? to_px(wq) : '0;
        b.height_px = b.keep ? to_px(hq) : '0;
        b.index     = n;
        b.last      = (n == NUM_ANCHORS - 1);
        return b;
    endfunction

    function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            REG_FRAME_WIDTH:     frame_w   = val[FRAME_BITS-1:0];
            REG_FRAME_HEIGHT:    frame_h   = val[FRAME_BITS-1:0];
            REG_SCORE_THRESHOLD: score_thr = val[DATA_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_row item_row(input int s, x, y, w, h);
        t_row r;
        r.kind    = ROW_ITEM;
        r.det     = {16'(s), 16'(x), 16'(y), 16'(w), 16'(h)};
        r.reg_idx = '0;
        r.reg_val = '0;
        r.fixed   = 1'b0;
        r.box     = '0;
        return r;
    endfunction

    // a row whose box is read straight off the decode rules; index comes from the counter
    function automatic t_row fixed_row(input int s, x, y, w, h, input int k, l, t, wd, ht);
        t_row r;
        r = item_row(s, x, y, w, h);
        r.fixed         = 1'b1;
        r.box.keep      = k[0];
        r.box.left_px   = l[PIX_W-1:0];
        r.box.top_px    = t[PIX_W-1:0];
        r.box.width_px  = wd[PIX_W-1:0];
        r.box.height_px = ht[PIX_W-1:0];
        return r;
    endfunction

    function automatic t_row reg_row(input logic [1:0] idx, input logic [31:0] val);
        t_row r;
        r         = item_row(0, 0, 0, 0, 0);
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // mostly plausible faces with random content, the rest raw noise over all bits
    function automatic t_det random_det();
        t_det d;
        if ($urandom_range(0, 3) == 0) begin
            d.score = 16'($urandom());
            d.x_ctr = 16'($urandom());
            d.y_ctr = 16'($urandom());
            d.w     = 16'($urandom());
            d.h     = 16'($urandom());
        end else begin
            d.score = 16'($urandom_range(0, 32767));
            d.x_ctr = 16'(int'($urandom_range(0, 6000)) - 1500);
            d.y_ctr = 16'(int'($urandom_range(0, 6000)) - 1500);
            d.w     = 16'($urandom_range(0, 6000));
            d.h     = 16'($urandom_range(0, 6000));
        end
        return d;
    endfunction

    // apb write: setup, access, register takes the value at the access edge
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // apb read, compared on the register's own width only
    task automatic check_reg(input logic [1:0] idx);
        logic [CFG_DATA_W-1:0] got;
        bit                    ok;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_FRAME_WIDTH: begin
                ok = (got[FRAME_BITS-1:0] === frame_w);
                if (!ok) report_mismatch("frame width read-back", got[FRAME_BITS-1:0], frame_w);
            end
            REG_FRAME_HEIGHT: begin
                ok = (got[FRAME_BITS-1:0] === frame_h);
                if (!ok) report_mismatch("frame height read-back", got[FRAME_BITS-1:0], frame_h);
            end
            REG_SCORE_THRESHOLD: begin
                ok = (got[DATA_W-1:0] === score_thr);
                if (!ok) report_mismatch("threshold read-back", got[DATA_W-1:0], score_thr);
            end
            default: ;
        endcase
    endtask

    // one input transfer, with an occasional gap in front of it; valid stays high after
    task automatic send_det(input t_det d, input bit fixed, input t_box box);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        fixed_q.insert(fixed_q.size(), t_fixed'{fixed, box});
        in_ch.valid        <= 1'b1;
        in_ch.score        <= d.score;
        in_ch.raw_x_center <= d.x_ctr;
        in_ch.raw_y_center <= d.y_ctr;
        in_ch.raw_width    <= d.w;
        in_ch.raw_height   <= d.h;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // stop sending and hold off until every predicted box has come out
    task automatic wait_boxes_out();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (box_due_q.size() != 0) @(posedge i_clk);
    endtask

    // sink side: bursts of stall, then runs of ready, none once quiet
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // prediction at each input transfer, checking at each output transfer;
    // both sample pre-edge values so the order against the driver does not matter
    always @(posedge i_clk) begin : box_monitor
        t_det   det;
        t_box   want;
        t_box   got;
        t_fixed fx;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            det  = {in_ch.score, in_ch.raw_x_center, in_ch.raw_y_center,
                    in_ch.raw_width, in_ch.raw_height};
            want = decode_box(det, anchor_now);
            anchor_now = (anchor_now == NUM_ANCHORS - 1) ? '0 : anchor_now + 1'b1;
            if (fixed_q.size() != 0) begin
                fx = fixed_q.pop_front();
                if (fx.used) begin
                    want.keep      = fx.box.keep;
                    want.left_px   = fx.box.left_px;
                    want.top_px    = fx.box.top_px;
                    want.width_px  = fx.box.width_px;
                    want.height_px = fx.box.height_px;
                end
            end
            box_due_q.insert(box_due_q.size(), want);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.keep, out_ch.box_left, out_ch.box_top, out_ch.box_width_px,
                   out_ch.box_height_px, out_ch.anchor_index, out_ch.last_anchor};
            if (box_due_q.size() == 0) begin
                report_mismatch("box with none due, anchor", got.index, -1);
            end else begin
                want = box_due_q.pop_front();
                if (got.keep !== want.keep)
                    report_mismatch("keep", got.keep, want.keep);
                if (got.left_px !== want.left_px)
                    report_mismatch("box_left", got.left_px, want.left_px);
                if (got.top_px !== want.top_px)
                    report_mismatch("box_top", got.top_px, want.top_px);
                if (got.width_px !== want.width_px)
                    report_mismatch("box_width_px", got.width_px, want.width_px);
                if (got.height_px !== want.height_px)
                    report_mismatch("box_height_px", got.height_px, want.height_px);
                if (got.index !== want.index)
                    report_mismatch("anchor_index", got.index, want.index);
                if (got.last !== want.last)
                    report_mismatch("last_anchor", got.last, want.last);
            end
        end
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("tb_ssd_anchor_box_decoder_unit failed");
        $finish;
    end

    initial begin
        t_row        row;
        t_det        d;
        t_box        no_box;
        int          settle;
        logic [31:0] fw_val, fh_val, thr_val;

        no_box = '0;
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.score        <= '0;
        in_ch.raw_x_center <= '0;
        in_ch.raw_y_center <= '0;
        in_ch.raw_width    <= '0;
        in_ch.raw_height   <= '0;

        // directed rows, reset registers first: 640 x 480, threshold 0.5
        add_row(fixed_row(0, 0, 0, 0, 0,           0, 0, 0, 0, 0));
        // anchor 1 sits at (1/32, 1/32): 20 px across 640, 15 px down 480
        add_row(fixed_row(129, 0, 0, 0, 0,         1, 20, 15, 0, 0));
        // a score equal to the threshold does not pass
        add_row(fixed_row(128, 0, 0, 0, 0,         0, 0, 0, 0, 0));
        add_row(fixed_row(-32768, 0, 0, 0, 0,      0, 0, 0, 0, 0));
        // negative left, width, height, top in turn
        add_row(fixed_row(32767, -32768, 0, 0, 0,  0, 0, 0, 0, 0));
        add_row(fixed_row(32767, 0, 0, -1, 0,      0, 0, 0, 0, 0));
        add_row(fixed_row(32767, 0, 0, 0, -32768,  0, 0, 0, 0, 0));
        add_row(fixed_row(32767, 0, -32768, 0, 0,  0, 0, 0, 0, 0));
        add_row(item_row(32767, 32767, 32767, 32767, 32767));
        add_row(item_row(32767, -1, -1, 1, 1));
        add_row(item_row(300, 5000, -200, 4000, 3000));
        // widest frame through a value with junk above the field, zero height,
        // lowest threshold, and a write to an unmapped index
        add_row(reg_row(REG_FRAME_WIDTH, 32'hABCD_FFFF));
        add_row(reg_row(REG_FRAME_HEIGHT, 32'h0000_0000));
        add_row(reg_row(REG_SCORE_THRESHOLD, 32'hFFFF_8000));
        add_row(reg_row(REG_UNMAPPED, 32'h0000_1234));
        // left edge far past the pixel range clamps; zero height scales to zero and stays kept
        add_row(fixed_row(-32767, 32767, 0, 0, 0,  1, PIX_MAX, 0, 0, 0));
        add_row(fixed_row(-32768, 0, 0, 0, 0,      0, 0, 0, 0, 0));
        add_row(item_row(0, 32767, -32768, 32767, -32768));
        // zero width as well: everything scales to zero
        add_row(reg_row(REG_FRAME_WIDTH, 32'h0000_0000));
        add_row(fixed_row(0, 0, 0, 100, 100,       1, 0, 0, 0, 0));
        // highest threshold: nothing can pass
        add_row(reg_row(REG_FRAME_WIDTH, 32'h0000_0001));
        add_row(reg_row(REG_FRAME_HEIGHT, 32'h0000_0FFF));
        add_row(reg_row(REG_SCORE_THRESHOLD, 32'h0000_7FFF));
        add_row(fixed_row(32767, 0, 0, 0, 0,       0, 0, 0, 0, 0));
        add_row(fixed_row(32767, 1000, 0, 500, 0,  0, 0, 0, 0, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset values must read back before anything is written
        check_reg(REG_FRAME_WIDTH);
        check_reg(REG_FRAME_HEIGHT);
        check_reg(REG_SCORE_THRESHOLD);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_REG) begin
                // registers only change with the pipeline empty
                wait_boxes_out();
                write_reg(row.reg_idx, row.reg_val);
                if (row.reg_idx != REG_UNMAPPED)
                    check_reg(row.reg_idx);
            end else begin
                send_det(row.det, row.fixed, row.box);
            end
        end
        // the unmapped write must have left all three alone
        wait_boxes_out();
        check_reg(REG_FRAME_WIDTH);
        check_reg(REG_FRAME_HEIGHT);
        check_reg(REG_SCORE_THRESHOLD);

        // random phases, each under its own register setting; the counter runs on
        // across phases so both grids and the wrap at the last anchor come round
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    fw_val  = 32'd640;
                    fh_val  = 32'd480;
                    thr_val = 32'd128;
                end
                1: begin
                    fw_val  = $urandom_range(1, 16);
                    fh_val  = $urandom_range(1, 16);
                    thr_val = 32'(int'($urandom_range(0, 1023)) - 512);
                end
                2: begin
                    fw_val  = 32'd4095;
                    fh_val  = 32'd4095;
                    thr_val = 32'hFFFF_8000;
                end
                default: begin
                    fw_val  = ($urandom() & ~32'hFFF) | $urandom_range(1, 4095);
                    fh_val  = ($urandom() & ~32'hFFF) | $urandom_range(1, 4095);
                    thr_val = {16'($urandom()), 16'(int'($urandom_range(0, 2047)) - 1024)};
                end
            endcase
            wait_boxes_out();
            write_reg(REG_FRAME_WIDTH, fw_val);
            write_reg(REG_FRAME_HEIGHT, fh_val);
            write_reg(REG_SCORE_THRESHOLD, thr_val);
            check_reg(REG_FRAME_WIDTH);
            check_reg(REG_FRAME_HEIGHT);
            check_reg(REG_SCORE_THRESHOLD);
            // last phase runs flat out on both sides
            quiet = (phase == NUM_PHASES - 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // once, midway through phase 1, let the pipeline run dry before carrying on
                if (phase == 1 && k == PHASE_ITEMS / 2)
                    wait_boxes_out();
                d = random_det();
                send_det(d, 1'b0, no_box);
            end
        end

        in_ch.valid <= 1'b0;
        settle = 0;
        while (box_due_q.size() != 0 && settle < 20000) begin
            @(posedge i_clk);
            settle++;
        end
        // let the clock run on to catch any stray transfer
        repeat (6) @(posedge i_clk);
        if (box_due_q.size() != 0)
            report_mismatch("boxes never delivered", 0, box_due_q.size());

        if (mismatch_cnt == 0)
            $display("tb_ssd_anchor_box_decoder_unit passed");
        else
            $display("tb_ssd_anchor_box_decoder_unit failed");
        $finish;
    end

endmodule
